// ===== rtl/core/ihexw_pkg.sv =====
// ihexw_pkg: shared types, constants and helpers for the Intel HEX record writer
// no dependencies; used by every other file under rtl/core

package ihexw_pkg;

  localparam int MAX_RECORD_BYTES = 32;
  localparam int ADDR_W           = 16;
  localparam int BYTE_W           = 8;
  localparam int CHAR_W           = 7;
  localparam int REC_LEN_W        = 6;
  localparam int CNT_W            = 6;
  localparam int JOB_QUEUE_DEPTH  = 2;

  localparam logic [REC_LEN_W-1:0] RECORD_LENGTH_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_SET     = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef enum logic {
    REC_DATA = 1'b0,
    REC_EOF  = 1'b1
  } rec_type_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    rec_type_t         rtype;
    logic              bank;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [CNT_W-1:0]  index;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + CHAR_W'(nib);
    end else begin
      c = 7'h37 + CHAR_W'(nib);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ihexw_queue.sv =====
// ihexw_queue: short job queue between the front and the back
// depends on ihexw_pkg

module ihexw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ihexw_pkg::job_t job_in,
  output logic            free,
  output logic            valid,
  output ihexw_pkg::job_t job_out,
  input  logic            pop
);

  localparam int DEPTH = ihexw_pkg::JOB_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  ihexw_pkg::job_t entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]   level_r, level_nxt;
  logic            do_push, do_pop;

  assign free    = level_r != LW'(DEPTH);
  assign valid   = level_r != '0;
  assign do_push = push && free;
  assign do_pop  = pop && valid;
  assign job_out = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

// ===== rtl/core/ihexw_front.sv =====
// ihexw_front: input stage, address tracking and run buffering, issues record jobs
// depends on ihexw_pkg

module ihexw_front #(
  parameter int MAX_RECORD_BYTES = ihexw_pkg::MAX_RECORD_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [1:0]                         in_command,
  input  logic [ihexw_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic [ihexw_pkg::ADDR_W-1:0]       in_new_address,
  input  logic [ihexw_pkg::ADDR_W-1:0]       in_skip_count,
  input  logic [ihexw_pkg::ADDR_W-1:0]       in_start_address,
  input  logic                               cfg_valid,
  input  logic [ihexw_pkg::REC_LEN_W-1:0]    cfg_data,
  input  logic                               q_free,
  output logic                               q_push,
  output ihexw_pkg::job_t                    q_job,
  output ihexw_pkg::mem_wr_t                 wr,
  input  ihexw_pkg::release_t                rel
);

  localparam int AW = ihexw_pkg::ADDR_W;
  localparam int CW = ihexw_pkg::CNT_W;
  localparam int LW = ihexw_pkg::REC_LEN_W;

  logic                            stage_valid_r, stage_valid_nxt;
  ihexw_pkg::cmd_t                 st_cmd_r;
  logic [ihexw_pkg::BYTE_W-1:0]    st_data_r;
  logic [AW-1:0]                   st_new_r, st_skip_r, st_start_r;

  logic [AW-1:0]  cur_addr_r, cur_addr_nxt;
  logic [AW-1:0]  rec_addr_r, rec_addr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           bank_r, bank_nxt;
  logic [1:0]     busy_r, busy_nxt;
  logic [LW-1:0]  rec_len_r;
  logic [LW-1:0]  eff_len;

  logic           accept, fire;
  logic           run_break, full_run, flush, emit, can_switch;
  logic [CW-1:0]  base;

  always_comb begin
    if (rec_len_r == '0) begin
      eff_len = LW'(1);
    end else if (rec_len_r > LW'(MAX_RECORD_BYTES)) begin
      eff_len = LW'(MAX_RECORD_BYTES);
    end else begin
      eff_len = rec_len_r;
    end
  end

  assign run_break  = (rec_addr_r + AW'(cnt_r)) != cur_addr_r;
  assign full_run   = LW'(cnt_r) >= eff_len;
  assign flush      = run_break || full_run;
  assign emit       = flush && (cnt_r != '0);
  assign can_switch = q_free && !busy_r[~bank_r];
  assign base       = flush ? '0 : cnt_r;

  always_comb begin
    fire         = 1'b0;
    q_push       = 1'b0;
    q_job        = '0;
    wr           = '0;
    cur_addr_nxt = cur_addr_r;
    rec_addr_nxt = rec_addr_r;
    cnt_nxt      = cnt_r;
    bank_nxt     = bank_r;
    if (stage_valid_r) begin
      unique case (st_cmd_r)
        ihexw_pkg::CMD_WRITE: begin
          if (!emit || can_switch) begin
            fire = 1'b1;
            if (emit) begin
              q_push       = 1'b1;
              q_job.addr   = rec_addr_r;
              q_job.count  = cnt_r;
              q_job.rtype  = ihexw_pkg::REC_DATA;
              q_job.bank   = bank_r;
              q_job.last   = 1'b1;
              bank_nxt     = ~bank_r;
            end
            wr.en        = 1'b1;
            wr.bank      = emit ? ~bank_r : bank_r;
            wr.index     = base;
            wr.data      = st_data_r;
            cnt_nxt      = base + CW'(1);
            rec_addr_nxt = flush ? cur_addr_r : rec_addr_r;
            cur_addr_nxt = cur_addr_r + AW'(1);
          end
        end
        ihexw_pkg::CMD_SET: begin
          fire         = 1'b1;
          cur_addr_nxt = st_new_r;
        end
        ihexw_pkg::CMD_ADVANCE: begin
          fire         = 1'b1;
          cur_addr_nxt = cur_addr_r + st_skip_r;
        end
        ihexw_pkg::CMD_END: begin
          if (cnt_r != '0) begin
            // data record first, the end record follows on a later cycle
            if (can_switch) begin
              q_push       = 1'b1;
              q_job.addr   = rec_addr_r;
              q_job.count  = cnt_r;
              q_job.rtype  = ihexw_pkg::REC_DATA;
              q_job.bank   = bank_r;
              q_job.last   = 1'b0;
              bank_nxt     = ~bank_r;
              cnt_nxt      = '0;
              rec_addr_nxt = cur_addr_r;
            end
          end else if (q_free) begin
            fire         = 1'b1;
            q_push       = 1'b1;
            q_job.addr   = st_start_r;
            q_job.count  = '0;
            q_job.rtype  = ihexw_pkg::REC_EOF;
            q_job.bank   = bank_r;
            q_job.last   = 1'b1;
            rec_addr_nxt = st_start_r;
          end
        end
        default: begin
          fire = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push && (q_job.rtype == ihexw_pkg::REC_DATA)) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  assign in_full = stage_valid_r && !fire;
  assign accept  = in_push && !in_full;

  always_comb begin
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      cur_addr_r    <= '0;
      rec_addr_r    <= '0;
      cnt_r         <= '0;
      bank_r        <= 1'b0;
      busy_r        <= '0;
      rec_len_r     <= ihexw_pkg::RECORD_LENGTH_RESET;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      cur_addr_r    <= cur_addr_nxt;
      rec_addr_r    <= rec_addr_nxt;
      cnt_r         <= cnt_nxt;
      bank_r        <= bank_nxt;
      busy_r        <= busy_nxt;
      if (cfg_valid) begin
        rec_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd_r   <= ihexw_pkg::cmd_t'(in_command);
      st_data_r  <= in_data_byte;
      st_new_r   <= in_new_address;
      st_skip_r  <= in_skip_count;
      st_start_r <= in_start_address;
    end
  end

endmodule

// ===== rtl/core/ihexw_back.sv =====
// ihexw_back: record buffer memory and record sequencer, one hex pair per cycle while out_pop keeps up
// depends on ihexw_pkg

module ihexw_back #(
  parameter int MAX_RECORD_BYTES = ihexw_pkg::MAX_RECORD_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  ihexw_pkg::job_t                  q_job,
  output logic                             q_pop,
  input  ihexw_pkg::mem_wr_t               wr,
  output ihexw_pkg::release_t              rel,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [ihexw_pkg::CHAR_W-1:0]     out_hex_high,
  output logic [ihexw_pkg::CHAR_W-1:0]     out_hex_low,
  output logic                             out_record_start,
  output logic                             out_record_end,
  output logic                             out_last
);

  localparam int IW    = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int MEM_D = 2 ** (IW + 1);
  localparam int CW    = ihexw_pkg::CNT_W;
  localparam int BW    = ihexw_pkg::BYTE_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_COUNT = 7'b0000010,
    ST_ADHI  = 7'b0000100,
    ST_ADLO  = 7'b0001000,
    ST_TYPE  = 7'b0010000,
    ST_DATA  = 7'b0100000,
    ST_CSUM  = 7'b1000000
  } state_t;

  logic [BW-1:0]   mem [MEM_D];
  logic [BW-1:0]   rd_data_r;
  logic            rd_en;
  logic [CW-1:0]   rd_idx;

  state_t          state_r, state_nxt;
  ihexw_pkg::job_t job_r;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [BW-1:0]   sum_r, sum_nxt;

  logic            out_valid_r;
  logic            step, emit;
  logic [BW-1:0]   pair_byte;
  logic            pair_start, pair_end, pair_last;

  assign step      = !out_valid_r || out_pop;
  assign emit      = step && (state_r != ST_IDLE);
  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = '0;
    rel        = '0;
    pair_byte  = '0;
    pair_start = 1'b0;
    pair_end   = 1'b0;
    pair_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        pair_byte  = BW'(job_r.count);
        pair_start = 1'b1;
        if (step) begin
          state_nxt = ST_ADHI;
        end
      end
      ST_ADHI: begin
        pair_byte = job_r.addr[15:8];
        if (step) begin
          state_nxt = ST_ADLO;
        end
      end
      ST_ADLO: begin
        pair_byte = job_r.addr[7:0];
        if (step) begin
          state_nxt = ST_TYPE;
        end
      end
      ST_TYPE: begin
        pair_byte = BW'(job_r.rtype);
        if (step) begin
          idx_nxt = '0;
          if (job_r.count == '0) begin
            state_nxt = ST_CSUM;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = '0;
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        pair_byte = rd_data_r;
        if (step) begin
          if (idx_r == job_r.count - CW'(1)) begin
            state_nxt = ST_CSUM;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = idx_r + CW'(1);
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      ST_CSUM: begin
        pair_byte = BW'(0) - sum_r;
        pair_end  = 1'b1;
        pair_last = job_r.last;
        if (step) begin
          state_nxt = ST_IDLE;
          rel.en    = job_r.rtype == ihexw_pkg::REC_DATA;
          rel.bank  = job_r.bank;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sum_nxt = sum_r;
    if (emit) begin
      sum_nxt = (state_r == ST_COUNT) ? pair_byte : sum_r + pair_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    if (emit) begin
      out_hex_high     <= ihexw_pkg::hex_char(pair_byte[7:4]);
      out_hex_low      <= ihexw_pkg::hex_char(pair_byte[3:0]);
      out_record_start <= pair_start;
      out_record_end   <= pair_end;
      out_last         <= pair_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.index[IW-1:0]}] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[{job_r.bank, rd_idx[IW-1:0]}];
    end
  end

endmodule

// ===== rtl/core/intel_hex_record_writer.sv =====
// Intel HEX record writer: input stage and run buffer (ihexw_front), job queue
// (ihexw_queue) and record sequencer (ihexw_back); depends on ihexw_pkg
//
// Commands enter through a one-deep input stage; an end command with buffered data
// sends a data record first, then the end record. Records leave the back at one
// hex pair per cycle while out_pop keeps up: a record of n data bytes costs n + 5
// pairs, and the back fetches each job in its idle state before the count pair.
// The record buffer is a two-bank memory: the front fills one bank while the back
// reads the other, and a write that closes a record waits only while the back
// still holds the bank it would move to or the two-entry job queue is full. No
// clearing pass is needed after reset. cfg_ready is always high. The user must
// write record_length only while the block is idle; the block does not enforce it.

module intel_hex_record_writer #(
  parameter int MAX_RECORD_BYTES = ihexw_pkg::MAX_RECORD_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [1:0]                       in_command,
  input  logic [ihexw_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [ihexw_pkg::ADDR_W-1:0]     in_new_address,
  input  logic [ihexw_pkg::ADDR_W-1:0]     in_skip_count,
  input  logic [ihexw_pkg::ADDR_W-1:0]     in_start_address,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [ihexw_pkg::CHAR_W-1:0]     out_hex_high,
  output logic [ihexw_pkg::CHAR_W-1:0]     out_hex_low,
  output logic                             out_record_start,
  output logic                             out_record_end,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ihexw_pkg::REC_LEN_W-1:0]  cfg_data
);

  logic                q_push, q_free, q_valid, q_pop;
  ihexw_pkg::job_t     q_job_in, q_job_out;
  ihexw_pkg::mem_wr_t  wr;
  ihexw_pkg::release_t rel;

  assign cfg_ready = 1'b1;

  ihexw_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .in_new_address   (in_new_address),
    .in_skip_count    (in_skip_count),
    .in_start_address (in_start_address),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .q_free           (q_free),
    .q_push           (q_push),
    .q_job            (q_job_in),
    .wr               (wr),
    .rel              (rel)
  );

  ihexw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .free    (q_free),
    .valid   (q_valid),
    .job_out (q_job_out),
    .pop     (q_pop)
  );

  ihexw_back #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (q_job_out),
    .q_pop            (q_pop),
    .wr               (wr),
    .rel              (rel),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_hex_high     (out_hex_high),
    .out_hex_low      (out_hex_low),
    .out_record_start (out_record_start),
    .out_record_end   (out_record_end),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/core/ihexw_checker.sv =====
// ihexw_checker: port-level assertions for the Intel HEX record writer
// depends on ihexw_pkg; bound to intel_hex_record_writer

module ihexw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_full,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic [ihexw_pkg::CHAR_W-1:0]     out_hex_high,
  input logic [ihexw_pkg::CHAR_W-1:0]     out_hex_low,
  input logic                             out_record_start,
  input logic                             out_record_end,
  input logic                             out_last
);

  // queue reads empty and takes transactions right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!in_full && out_empty))
    else $error("not clear after reset");

  a_hex_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (((out_hex_high >= 7'h30) && (out_hex_high <= 7'h39)) ||
                    ((out_hex_high >= 7'h41) && (out_hex_high <= 7'h46))) &&
                   (((out_hex_low >= 7'h30) && (out_hex_low <= 7'h39)) ||
                    ((out_hex_low >= 7'h41) && (out_hex_low <= 7'h46))))
    else $error("result is not an uppercase hex pair");

  // count byte and checksum byte never coincide
  a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_record_start && out_record_end))
    else $error("record start and end on one pair");

  a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> out_record_end)
    else $error("last result is not a checksum pair");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_hex_high) &&
                                  $stable(out_hex_low) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind intel_hex_record_writer ihexw_checker u_ihexw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_hex_high     (out_hex_high),
  .out_hex_low      (out_hex_low),
  .out_record_start (out_record_start),
  .out_record_end   (out_record_end),
  .out_last         (out_last)
);

// ===== dv/tb_intel_hex_record_writer.sv =====
// testbench for intel_hex_record_writer: drives commands through the push/full port,
// pops hex pairs and checks them against an internal record predictor
// depends on ihexw_pkg and the rtl under rtl/core

module tb_intel_hex_record_writer;
  import ihexw_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int CFG_SETTLE  = 16;
  localparam int END_SETTLE  = 64;

  class hex_record_tracker;
    typedef struct packed {
      logic [CHAR_W-1:0] hi;
      logic [CHAR_W-1:0] lo;
      logic              rs;
      logic              re;
      logic              lst;
    } hex_pair_t;

    hex_pair_t         pending_pairs[$];
    hex_pair_t         held;
    bit                held_valid;
    logic [REC_LEN_W-1:0] length_reg;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] run_addr;
    int unsigned       run_count;
    logic [BYTE_W-1:0] run_bytes[MAX_RECORD_BYTES];
    int                errors;

    function new();
      length_reg = RECORD_LENGTH_RESET;
      cur_addr   = '0;
      run_addr   = '0;
      run_count  = 0;
      held_valid = 0;
      errors     = 0;
    endfunction

    function void report(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endfunction

    function logic [CHAR_W-1:0] digit(logic [3:0] n);
      if (n > 4'd9) begin
        return 7'h41 + CHAR_W'(n - 4'd10);
      end
      return 7'h30 + CHAR_W'(n);
    endfunction

    // the newest pair is held back so the last one of a transaction can be flagged
    function void queue_pair(logic [BYTE_W-1:0] b, bit first, bit closing);
      hex_pair_t p;
      if (held_valid) begin
        pending_pairs.push_back(held);
      end
      p.hi = digit(b[7:4]);
      p.lo = digit(b[3:0]);
      p.rs = first;
      p.re = closing;
      p.lst = 1'b0;
      held = p;
      held_valid = 1;
    endfunction

    function void queue_record(rec_type_t rtype);
      logic [BYTE_W-1:0] sum;
      sum = BYTE_W'(run_count) + run_addr[15:8] + run_addr[7:0] + BYTE_W'(rtype);
      queue_pair(BYTE_W'(run_count), 1, 0);
      queue_pair(run_addr[15:8], 0, 0);
      queue_pair(run_addr[7:0], 0, 0);
      queue_pair(BYTE_W'(rtype), 0, 0);
      for (int i = 0; i < int'(run_count); i++) begin
        queue_pair(run_bytes[i], 0, 0);
        sum = sum + run_bytes[i];
      end
      queue_pair(~sum + 8'd1, 0, 1);
    endfunction

    function void flush_run();
      if (run_count != 0) begin
        queue_record(REC_DATA);
        run_count = 0;
      end
      run_addr = cur_addr;
    endfunction

    function int unsigned usable_length();
      if (length_reg == 0) begin
        return 1;
      end
      if (length_reg > MAX_RECORD_BYTES) begin
        return MAX_RECORD_BYTES;
      end
      return length_reg;
    endfunction

    function void note_command(cmd_t c, logic [BYTE_W-1:0] d, logic [ADDR_W-1:0] na,
                               logic [ADDR_W-1:0] sc, logic [ADDR_W-1:0] sa);
      logic [ADDR_W-1:0] run_next;
      run_next = run_addr + ADDR_W'(run_count);
      case (c)
        CMD_WRITE: begin
          if (run_next != cur_addr) begin
            flush_run();
          end
          if (run_count >= usable_length()) begin
            flush_run();
          end
          if (run_count < MAX_RECORD_BYTES) begin
            run_bytes[run_count] = d;
            run_count++;
          end
          cur_addr = cur_addr + 16'd1;
        end
        CMD_SET: begin
          cur_addr = na;
        end
        CMD_ADVANCE: begin
          cur_addr = cur_addr + sc;
        end
        default: begin
          flush_run();
          run_count = 0;
          run_addr = sa;
          queue_record(REC_EOF);
        end
      endcase
      if (held_valid) begin
        held.lst = 1'b1;
        pending_pairs.push_back(held);
        held_valid = 0;
      end
    endfunction

    function void check_pair(logic [CHAR_W-1:0] hi, logic [CHAR_W-1:0] lo,
                             logic rs, logic re, logic lst);
      hex_pair_t want;
      if (pending_pairs.size() == 0) begin
        report($sformatf("unexpected pair %c%c", hi, lo));
        return;
      end
      want = pending_pairs.pop_front();
      if (hi !== want.hi) report($sformatf("hex_high %h, want %h", hi, want.hi));
      if (lo !== want.lo) report($sformatf("hex_low %h, want %h", lo, want.lo));
      if (rs !== want.rs) report($sformatf("record_start %b, want %b", rs, want.rs));
      if (re !== want.re) report($sformatf("record_end %b, want %b", re, want.re));
      if (lst !== want.lst) report($sformatf("last %b, want %b", lst, want.lst));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [1:0]           in_command = CMD_WRITE;
  logic [BYTE_W-1:0]    in_data_byte = '0;
  logic [ADDR_W-1:0]    in_new_address = '0;
  logic [ADDR_W-1:0]    in_skip_count = '0;
  logic [ADDR_W-1:0]    in_start_address = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [CHAR_W-1:0]    out_hex_high;
  logic [CHAR_W-1:0]    out_hex_low;
  logic                 out_record_start;
  logic                 out_record_end;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REC_LEN_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  hex_record_tracker tracker;

  intel_hex_record_writer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .in_new_address   (in_new_address),
    .in_skip_count    (in_skip_count),
    .in_start_address (in_start_address),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hex_high     (out_hex_high),
    .out_hex_low      (out_hex_low),
    .out_record_start (out_record_start),
    .out_record_end   (out_record_end),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      tracker.check_pair(out_hex_high, out_hex_low, out_record_start, out_record_end,
                         out_last);
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ends the run when no transaction moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb_intel_hex_record_writer: done, errors");
    $finish;
  end

  task automatic push_command(input cmd_t c, input logic [ADDR_W-1:0] v);
    logic [BYTE_W-1:0] d;
    logic [ADDR_W-1:0] na;
    logic [ADDR_W-1:0] sc;
    logic [ADDR_W-1:0] sa;
    d  = (c == CMD_WRITE) ? v[7:0] : BYTE_W'($urandom);
    na = (c == CMD_SET) ? v : ADDR_W'($urandom);
    sc = (c == CMD_ADVANCE) ? v : ADDR_W'($urandom);
    sa = (c == CMD_END) ? v : ADDR_W'($urandom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_command       <= c;
    in_data_byte     <= d;
    in_new_address   <= na;
    in_skip_count    <= sc;
    in_start_address <= sa;
    do @(posedge clk); while (in_full);
    tracker.note_command(c, d, na, sc, sa);
  endtask

  task automatic drain(input int settle);
    in_push <= 1'b0;
    while (tracker.pending_pairs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_length(input logic [REC_LEN_W-1:0] v);
    drain(CFG_SETTLE);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.length_reg = v;
  endtask

  task automatic run_random(input int items);
    int sent;
    int kind;
    int run;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        push_command(CMD_SET, (kind % 3 == 0) ? (16'hFFE0 | 16'($urandom_range(0, 31)))
                                              : ADDR_W'($urandom));
        sent++;
      end else if (kind < 22) begin
        case (kind % 4)
          0: push_command(CMD_ADVANCE, 16'h0000);
          1: push_command(CMD_ADVANCE, 16'($urandom_range(1, 40)));
          2: push_command(CMD_ADVANCE, 16'hFFFF);
          default: push_command(CMD_ADVANCE, ADDR_W'($urandom));
        endcase
        sent++;
      end else if (kind < 27) begin
        push_command(CMD_END, ADDR_W'($urandom));
        sent++;
      end
      run = (kind % 3 == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      repeat (run) push_command(CMD_WRITE, ADDR_W'($urandom));
      sent += run;
    end
  endtask

  initial begin
    int lengths[7];
    tracker = new();
    lengths = '{1, 0, 63, 7, 0, 33, 32};
    lengths[4] = $urandom_range(2, 31);
    send_idle_pct = 9;
    recv_idle_pct = 46;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme bytes and nibble digits
    push_command(CMD_WRITE, 16'h0000);
    push_command(CMD_WRITE, 16'h00FF);
    push_command(CMD_WRITE, 16'h00A5);
    push_command(CMD_WRITE, 16'h005A);
    // jump flushes the run, next run wraps past ffff in one record
    push_command(CMD_SET, 16'hFFFE);
    push_command(CMD_WRITE, 16'h0012);
    push_command(CMD_WRITE, 16'h0034);
    push_command(CMD_WRITE, 16'h0056);
    push_command(CMD_ADVANCE, 16'hFFFF);
    push_command(CMD_WRITE, 16'h0080);
    push_command(CMD_ADVANCE, 16'h0000);
    push_command(CMD_WRITE, 16'h0001);
    // end with data, then end with an empty buffer
    push_command(CMD_END, 16'hFFFF);
    push_command(CMD_END, 16'h0000);
    push_command(CMD_WRITE, 16'h007E);
    push_command(CMD_SET, 16'h8000);
    push_command(CMD_ADVANCE, 16'h8000);
    push_command(CMD_WRITE, 16'h00C3);
    push_command(CMD_END, 16'h1234);

    for (int p = 0; p < 7; p++) begin
      write_length(REC_LEN_W'(lengths[p]));
      if (p < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 46;
      end else if (p < 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_random(46);
    end

    drain(END_SETTLE);
    if (tracker.errors == 0) begin
      $display("tb_intel_hex_record_writer: done, clean");
    end else begin
      $display("tb_intel_hex_record_writer: done, errors");
    end
    $finish;
  end

endmodule
